@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DTOK_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define DTOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dtok_pkg.sv @@
// Shared constants, types and helper functions for the delimiter tokenizer.
// No dependencies; every other RTL file except assert_macros.svh imports this package.
`default_nettype none

package dtok_pkg;

    localparam int POS_BITS   = 16;
    localparam int SET_SLOTS  = 8;
    localparam int DEPTH_BITS = 8;
    localparam int OUT_BITS   = 16;
    localparam int SET_BITS   = 64;
    localparam int ADDR_BITS  = 5;

    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);

    typedef logic [POS_BITS-1:0]   t_pos;
    typedef logic [POS_BITS:0]     t_pos_ext;
    typedef logic [DEPTH_BITS-1:0] t_depth;
    typedef logic [OUT_BITS-1:0]   t_out;
    typedef logic [QPTR_BITS-1:0]  t_qptr;
    typedef logic [QPTR_BITS:0]    t_qcnt;

    localparam t_pos   POS_MAX   = {POS_BITS{1'b1}};
    localparam t_depth DEPTH_MAX = {DEPTH_BITS{1'b1}};

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [1:0] MODE_SPLIT = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_SEP    = 2'd1;
    localparam logic [1:0] REG_SINGLE = 2'd2;
    localparam logic [1:0] REG_STOP   = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SET_BITS-1:0] sep_set;
        logic [SET_BITS-1:0] single_set;
        logic [SET_BITS-1:0] stop_set;
    } t_cfg;

    typedef struct packed {
        t_out offset;
        t_out length;
        logic done;
        logic last;
        logic ovf;
    } t_res;

    // One queue entry carries every result of one input byte.
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_entry;

    function automatic logic in_set(input logic [SET_BITS-1:0] slots, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SET_SLOTS; i++) begin
            if (slots[8*i +: 8] != 8'd0 && slots[8*i +: 8] == c) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_out to_out(input t_pos_ext v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dtok_front.sv @@
// Front end: takes one byte per cycle while i_accept is high, tracks token
// state and builds the results of that byte as one queue entry. Depends on dtok_pkg.
`default_nettype none
`include "assert_macros.svh"

module dtok_front
    import dtok_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_accept,
    input  wire logic [7:0] i_ch,
    input  wire logic   i_final_byte,
    output logic        o_push,
    output t_entry      o_entry
);

    t_pos   r_pos, n_pos;
    t_pos   r_start, n_start;
    logic   r_in_tok, n_in_tok;
    logic   r_quote, n_quote;
    logic   r_esc, n_esc;
    t_depth r_depth, n_depth;

    logic   is_sep, is_single, is_stop, ovf, ends;
    logic [1:0] cnt;
    t_res   res [2];

    assign is_sep    = in_set(i_cfg.sep_set, i_ch);
    assign is_single = in_set(i_cfg.single_set, i_ch);
    assign is_stop   = in_set(i_cfg.stop_set, i_ch);
    assign ovf       = (r_pos == POS_MAX);

    always_comb begin
        n_pos    = r_pos;
        n_start  = r_start;
        n_in_tok = r_in_tok;
        n_quote  = r_quote;
        n_esc    = r_esc;
        n_depth  = r_depth;
        ends     = 1'b0;
        cnt      = 2'd0;
        for (int i = 0; i < 2; i++) begin
            res[i] = '{offset: '0, length: '0, done: 1'b0, last: 1'b0, ovf: ovf};
        end

        if (i_cfg.mode == MODE_SPLIT) begin
            if (!r_in_tok || is_sep || is_single) begin
                if (r_in_tok) begin
                    res[cnt[0]].offset = to_out({1'b0, r_start});
                    res[cnt[0]].length = to_out({1'b0, r_pos} - {1'b0, r_start});
                    cnt      = cnt + 2'd1;
                    n_in_tok = 1'b0;
                    n_quote  = 1'b0;
                    n_esc    = 1'b0;
                    n_depth  = '0;
                end
                if (is_sep) begin
                    // Separators are dropped.
                end else if (is_single) begin
                    res[cnt[0]].offset = to_out({1'b0, r_pos});
                    res[cnt[0]].length = to_out(t_pos_ext'(1));
                    cnt = cnt + 2'd1;
                end else begin
                    n_start  = r_pos;
                    n_in_tok = 1'b1;
                end
            end
        end else if (r_in_tok || !is_sep) begin
            if (!r_in_tok) begin
                n_start  = r_pos;
                n_in_tok = 1'b1;
            end
            if (i_cfg.mode == MODE_STOP) begin
                ends = is_stop;
            end else if (n_quote) begin
                if (n_esc) begin
                    n_esc = 1'b0;
                end else if (i_ch == CH_QUOTE) begin
                    n_quote = 1'b0;
                end else if (i_ch == CH_BSLASH) begin
                    n_esc = 1'b1;
                end
            end else if (i_ch == CH_QUOTE) begin
                n_quote = 1'b1;
                n_esc   = 1'b0;
            end else if (n_depth != '0) begin
                if (i_ch == CH_LPAREN) begin
                    if (n_depth != DEPTH_MAX) begin
                        n_depth = n_depth + t_depth'(1);
                    end
                end else if (i_ch == CH_RPAREN) begin
                    n_depth = n_depth - t_depth'(1);
                end
            end else if (i_ch == CH_LPAREN) begin
                n_depth = t_depth'(1);
            end else begin
                ends = is_stop;
            end
            if (ends) begin
                res[cnt[0]].offset = to_out({1'b0, n_start});
                res[cnt[0]].length = to_out({1'b0, r_pos} - {1'b0, n_start});
                cnt      = cnt + 2'd1;
                n_in_tok = 1'b0;
                n_quote  = 1'b0;
                n_esc    = 1'b0;
                n_depth  = '0;
            end
        end

        if (i_final_byte) begin
            if (n_in_tok) begin
                res[cnt[0]].offset = to_out({1'b0, n_start});
                res[cnt[0]].length =
                    to_out({1'b0, r_pos} - {1'b0, n_start} + t_pos_ext'(1));
                cnt = cnt + 2'd1;
            end else if (cnt == 2'd0) begin
                res[0].offset = to_out({1'b0, r_pos});
                res[0].length = '0;
                cnt = 2'd1;
            end
            res[cnt[1]].done = 1'b1;
            n_pos    = '0;
            n_start  = '0;
            n_in_tok = 1'b0;
            n_quote  = 1'b0;
            n_esc    = 1'b0;
            n_depth  = '0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + t_pos'(1);
        end

        // The last result of the byte sits in slot one only when there are two.
        if (cnt != 2'd0) begin
            res[cnt[1]].last = 1'b1;
        end
    end

    assign o_push  = i_accept && (cnt != 2'd0);
    assign o_entry = '{two: cnt[1], r0: res[0], r1: res[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_start  <= '0;
            r_in_tok <= 1'b0;
            r_quote  <= 1'b0;
            r_esc    <= 1'b0;
            r_depth  <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_in_tok <= n_in_tok;
            r_quote  <= n_quote;
            r_esc    <= n_esc;
            r_depth  <= n_depth;
        end
    end

    `DTOK_ASSERT(a_nest_needs_token, (r_quote || r_esc || r_depth != '0) |-> r_in_tok, "quote or paren state outside a token")

endmodule

`default_nettype wire

@@ rtl/core/dtok_queue.sv @@
// Short queue of result entries between the front end and the back end.
// Depends on dtok_pkg.
`default_nettype none
`include "assert_macros.svh"

module dtok_queue
    import dtok_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_avail,
    output t_entry      o_entry
);

    localparam t_qcnt CNT_ONE  = t_qcnt'(1);
    localparam t_qcnt CNT_FULL = t_qcnt'(QDEPTH);

    t_entry r_mem [QDEPTH];
    t_qptr  r_wr, r_rd;
    t_qcnt  r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_avail = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + t_qptr'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + t_qptr'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_ONE;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_ONE;
            end
        end
    end

    `DTOK_ASSERT(a_count_bound, r_count <= CNT_FULL, "queue count beyond depth")
    `DTOK_ASSERT_NEXT(a_count_drop, i_pop && !i_push, r_count == $past(r_count) - CNT_ONE, "queue count did not drop on pop")

endmodule

`default_nettype wire

@@ rtl/core/dtok_back.sv @@
// Back end: holds one queue entry and hands out its one or two results.
// Depends on dtok_pkg.
`default_nettype none
`include "assert_macros.svh"

module dtok_back
    import dtok_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_avail,
    input  wire t_entry i_entry,
    output logic        o_take,
    output logic        o_valid,
    output t_res        o_res,
    input  wire logic   i_pop
);

    t_entry r_ent;
    logic   r_idx;
    logic   r_valid;
    logic   pop_ok, entry_done;

    assign pop_ok     = i_pop && r_valid;
    assign entry_done = r_idx || !r_ent.two;
    assign o_take     = i_avail && (!r_valid || (pop_ok && entry_done));
    assign o_valid    = r_valid;
    assign o_res      = r_idx ? r_ent.r1 : r_ent.r0;

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 1'b0;
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_idx   <= 1'b0;
            r_valid <= 1'b1;
        end else if (pop_ok) begin
            if (entry_done) begin
                r_valid <= 1'b0;
                r_idx   <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

    `DTOK_ASSERT(a_second_slot, (r_valid && r_idx) |-> r_ent.two, "second result shown for a single-result entry")

endmodule

`default_nettype wire

@@ rtl/core/delimiter_tokenizer_core.sv @@
// Delimiter tokenizer: one byte in per cycle while full is low, tokens out as offset and length.
// A byte's results pass through the queue and the back-end holding register before they can be popped.
// One result per cycle out while pop is high and results are available; a byte that
// yields two results occupies the output for both of them, absorbed by a 4-entry queue.
// Reset (synchronous, active low) clears token state and queue and sets the config registers to defaults.
`default_nettype none

module delimiter_tokenizer_core
    import dtok_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_ch,
    input  wire logic                 i_final_byte,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [OUT_BITS-1:0]       o_token_offset,
    output logic [OUT_BITS-1:0]       o_token_length,
    output logic                      o_string_done,
    output logic                      o_last_of_run,
    output logic                      o_overflow,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [SET_BITS-1:0]  pwdata,
    output logic [SET_BITS-1:0]       prdata,
    output logic                      pready
);

    t_cfg   r_cfg;
    logic   [1:0] reg_idx;
    logic   cfg_wr, accept, q_push, q_full, q_avail, q_pop, out_valid;
    t_entry f_entry, q_entry;
    t_res   out_res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_SPLIT;
            r_cfg.sep_set    <= SET_BITS'(32);
            r_cfg.single_set <= '0;
            r_cfg.stop_set   <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MODE:   r_cfg.mode       <= pwdata[1:0];
                REG_SEP:    r_cfg.sep_set    <= pwdata;
                REG_SINGLE: r_cfg.single_set <= pwdata;
                REG_STOP:   r_cfg.stop_set   <= pwdata;
                default:    r_cfg.mode       <= r_cfg.mode;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:   prdata = SET_BITS'(r_cfg.mode);
            REG_SEP:    prdata = r_cfg.sep_set;
            REG_SINGLE: prdata = r_cfg.single_set;
            REG_STOP:   prdata = r_cfg.stop_set;
            default:    prdata = '0;
        endcase
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    dtok_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_ch         (i_ch),
        .i_final_byte (i_final_byte),
        .o_push       (q_push),
        .o_entry      (f_entry)
    );

    dtok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_entry (q_entry)
    );

    dtok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_entry (q_entry),
        .o_take  (q_pop),
        .o_valid (out_valid),
        .o_res   (out_res),
        .i_pop   (pop)
    );

    assign empty          = !out_valid;
    assign o_token_offset = out_res.offset;
    assign o_token_length = out_res.length;
    assign o_string_done  = out_res.done;
    assign o_last_of_run  = out_res.last;
    assign o_overflow     = out_res.ovf;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for delimiter_tokenizer_core: directed and random byte strings in all modes.
// Depends on dtok_pkg and the core RTL; expected tokens come from a predictor kept here.
// Idle and stall phases vary on both the byte side and the token side.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dtok_pkg::*;

    localparam logic [1:0] MODE_NEST     = 2'd2;
    localparam logic [1:0] MODE_NEST_ALT = 2'd3;
    localparam int         MAX_REPORTS   = 10;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         SEGMENT_BYTES = 70;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 push         = 1'b0;
    logic                 full;
    logic [7:0]           i_ch         = 8'h00;
    logic                 i_final_byte = 1'b0;
    logic                 empty;
    logic                 pop          = 1'b0;
    logic [OUT_BITS-1:0]  o_token_offset;
    logic [OUT_BITS-1:0]  o_token_length;
    logic                 o_string_done;
    logic                 o_last_of_run;
    logic                 o_overflow;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [ADDR_BITS-1:0] paddr        = '0;
    logic [SET_BITS-1:0]  pwdata       = '0;
    logic [SET_BITS-1:0]  prdata;
    logic                 pready;

    // Register copies and tokenizer state of the predictor.
    logic [1:0]          cfg_mode;
    logic [SET_BITS-1:0] cfg_sep;
    logic [SET_BITS-1:0] cfg_single;
    logic [SET_BITS-1:0] cfg_stop;
    t_pos                cur_pos;
    t_pos                tok_start;
    logic                in_tok;
    logic                in_quote;
    logic                esc_pend;
    t_depth              depth;

    t_res token_expect[$];
    int   mismatches    = 0;
    int   send_idle_pct = 0;
    int   pop_stall_pct = 0;

    delimiter_tokenizer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_ch           (i_ch),
        .i_final_byte   (i_final_byte),
        .empty          (empty),
        .pop            (pop),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_string_done  (o_string_done),
        .o_last_of_run  (o_last_of_run),
        .o_overflow     (o_overflow),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic byte_in_slots(input logic [SET_BITS-1:0] slots,
                                           input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SET_SLOTS; i++) begin
            if (slots[8*i +: 8] != 8'h00 && slots[8*i +: 8] == c) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void close_token();
        in_tok   = 1'b0;
        in_quote = 1'b0;
        esc_pend = 1'b0;
        depth    = '0;
    endfunction

    function automatic void predictor_reset();
        cfg_mode   = MODE_SPLIT;
        cfg_sep    = 64'd32;
        cfg_single = '0;
        cfg_stop   = '0;
        cur_pos    = '0;
        tok_start  = '0;
        close_token();
    endfunction

    function automatic t_res make_result(input t_pos off, input t_pos len, input logic ovf);
        return '{offset: t_out'(off), length: t_out'(len), done: 1'b0, last: 1'b0, ovf: ovf};
    endfunction

    // Stop-byte decision inside an open token; quote, escape and depth tracking apply
    // in the nesting modes only.
    function automatic logic stop_hit(input logic [1:0] md, input logic [7:0] c);
        if (md == MODE_STOP) return byte_in_slots(cfg_stop, c);
        if (in_quote) begin
            if (esc_pend) esc_pend = 1'b0;
            else if (c == CH_QUOTE) in_quote = 1'b0;
            else if (c == CH_BSLASH) esc_pend = 1'b1;
            return 1'b0;
        end
        if (c == CH_QUOTE) begin
            in_quote = 1'b1;
            esc_pend = 1'b0;
            return 1'b0;
        end
        if (depth != '0) begin
            if (c == CH_LPAREN) begin
                if (depth != DEPTH_MAX) depth++;
            end else if (c == CH_RPAREN) begin
                depth--;
            end
            return 1'b0;
        end
        if (c == CH_LPAREN) begin
            depth = t_depth'(1);
            return 1'b0;
        end
        return byte_in_slots(cfg_stop, c);
    endfunction

    function automatic void predict_tokens(input logic [7:0] c, input logic fin);
        t_res run [2];
        int   n;
        logic ovf;
        logic is_sep;
        logic is_single;
        n         = 0;
        ovf       = (cur_pos == POS_MAX);
        is_sep    = byte_in_slots(cfg_sep, c);
        is_single = byte_in_slots(cfg_single, c);
        if (cfg_mode == MODE_SPLIT) begin
            if (!in_tok || is_sep || is_single) begin
                if (in_tok) begin
                    run[n] = make_result(tok_start, t_pos'(cur_pos - tok_start), ovf);
                    n++;
                    close_token();
                end
                if (!is_sep) begin
                    if (is_single) begin
                        run[n] = make_result(cur_pos, t_pos'(1), ovf);
                        n++;
                    end else begin
                        tok_start = cur_pos;
                        in_tok    = 1'b1;
                    end
                end
            end
        end else if (in_tok || !is_sep) begin
            if (!in_tok) begin
                tok_start = cur_pos;
                in_tok    = 1'b1;
            end
            if (stop_hit(cfg_mode, c)) begin
                run[n] = make_result(tok_start, t_pos'(cur_pos - tok_start), ovf);
                n++;
                close_token();
            end
        end
        if (fin) begin
            if (in_tok) begin
                run[n] = make_result(tok_start, t_pos'(cur_pos - tok_start + 1'b1), ovf);
                n++;
            end else if (n == 0) begin
                run[n] = make_result(cur_pos, t_pos'(0), ovf);
                n++;
            end
            run[n-1].done = 1'b1;
            cur_pos   = '0;
            tok_start = '0;
            close_token();
        end else if (cur_pos != POS_MAX) begin
            cur_pos++;
        end
        for (int i = 0; i < n; i++) begin
            run[i].last = (i == n - 1);
            token_expect.push_back(run[i]);
        end
    endfunction

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance, with push still high.
    task automatic send_byte(input logic [7:0] c, input logic fin);
        logic taken;
        taken = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_ch         <= c;
        i_final_byte <= fin;
        while (!taken) begin
            @(posedge i_clk);
            taken = !full;
            if (taken) predict_tokens(c, fin);
            @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (token_expect.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [SET_BITS-1:0] val);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MODE:   cfg_mode   = val[1:0];
            REG_SEP:    cfg_sep    = val;
            REG_SINGLE: cfg_single = val;
            REG_STOP:   cfg_stop   = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_split_mode();
        write_reg(REG_SINGLE, 64'h0000_0000_0000_3B2C);
        send_text("  ab,c ;d");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(" ", 1'b1);
        send_text(" ");
        send_text("x;");
    endtask

    task automatic test_stop_mode();
        write_reg(REG_MODE, SET_BITS'(MODE_STOP));
        write_reg(REG_STOP, 64'h0000_0000_0000_7C3B);
        send_text("  a b;;c d");
        send_text("x|");
        send_text(";");
    endtask

    task automatic test_nest_mode();
        write_reg(REG_MODE, SET_BITS'(MODE_NEST));
        write_reg(REG_STOP, 64'h0000_0000_0000_002C);
        send_text("a\"x,\\\",y\",(b,(c)),d");
        send_text("\"ab,\\");
        send_text(" (a,");
        write_reg(REG_MODE, SET_BITS'(MODE_NEST_ALT));
        send_text("(p,q),r");
    endtask

    // A mode change while a quoted token is open must not leak quote state.
    task automatic test_mode_switch();
        write_reg(REG_MODE, SET_BITS'(MODE_NEST));
        send_byte("a", 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte("b", 1'b0);
        write_reg(REG_MODE, SET_BITS'(MODE_SPLIT));
        send_byte(",", 1'b0);
        send_byte("c", 1'b0);
        write_reg(REG_MODE, SET_BITS'(MODE_NEST));
        send_text("d,e");
    endtask

    task automatic test_set_extremes();
        write_reg(REG_MODE, SET_BITS'(MODE_STOP));
        write_reg(REG_SEP, '1);
        write_reg(REG_STOP, '1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b1);
        write_reg(REG_MODE, SET_BITS'(MODE_SPLIT));
        write_reg(REG_SEP, '0);
        write_reg(REG_STOP, '0);
        write_reg(REG_SINGLE, '1);
        send_byte(8'h20, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Opens more parentheses than the counter holds, so closing the saturated count
    // must bring the depth back to zero and let the stop byte end the token.
    task automatic test_depth_saturation();
        write_reg(REG_MODE, SET_BITS'(MODE_NEST));
        write_reg(REG_SEP, 64'd32);
        write_reg(REG_STOP, 64'h0000_0000_0000_002C);
        send_byte("x", 1'b0);
        repeat (300) send_byte(CH_LPAREN, 1'b0);
        repeat (int'(DEPTH_MAX)) send_byte(CH_RPAREN, 1'b0);
        send_byte(",", 1'b0);
        send_byte("z", 1'b1);
    endtask

    function automatic logic [SET_BITS-1:0] random_set();
        logic [SET_BITS-1:0] s;
        int                  pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(3) == 0) s[8*i +: 8] = 8'h00;
            else if ($urandom_range(1) == 0) s[8*i +: 8] = 8'($urandom_range(32, 47));
            else s[8*i +: 8] = 8'($urandom_range(255));
        end
        return s;
    endfunction

    function automatic logic [7:0] slot_byte(input logic [SET_BITS-1:0] slots);
        int k;
        k = $urandom_range(7);
        return slots[8*k +: 8];
    endfunction

    // Biased toward bytes that matter under the current registers.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 15) return slot_byte(cfg_sep);
        if (r < 25) return slot_byte(cfg_single);
        if (r < 40) return slot_byte(cfg_stop);
        if (r < 50) begin
            case ($urandom_range(3))
                0:       return CH_QUOTE;
                1:       return CH_LPAREN;
                2:       return CH_RPAREN;
                default: return CH_BSLASH;
            endcase
        end
        if (r < 80) return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(255));
    endfunction

    task automatic test_random_strings();
        int idle_plan [4][2];
        int sent;
        int len;
        idle_plan = '{'{0, 0}, '{54, 0}, '{0, 54}, '{28, 28}};
        for (int ph = 0; ph < 4; ph++) begin
            for (int seg = 0; seg < 2; seg++) begin
                write_reg(REG_MODE, {$urandom(), $urandom()});
                write_reg(REG_SEP, random_set());
                write_reg(REG_SINGLE, random_set());
                write_reg(REG_STOP, random_set());
                send_idle_pct = idle_plan[ph][0];
                pop_stall_pct = idle_plan[ph][1];
                sent = 0;
                while (sent < SEGMENT_BYTES) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(17, 40)
                                                   : $urandom_range(1, 12);
                    for (int i = 0; i < len; i++) begin
                        send_byte(pick_byte(), i == len - 1);
                    end
                    sent += len;
                end
            end
        end
        send_idle_pct = 0;
        pop_stall_pct = 0;
    endtask

    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (i_rst_n && pop && !empty) begin
            got = '{offset: o_token_offset, length: o_token_length, done: o_string_done,
                    last: o_last_of_run, ovf: o_overflow};
            if (token_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected token beat: off %0d len %0d done %0b last %0b ovf %0b",
                             got.offset, got.length, got.done, got.last, got.ovf);
            end else begin
                want = token_expect.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"token beat differs: expected off %0d len %0d done %0b ",
                                  "last %0b ovf %0b, got off %0d len %0d done %0b last %0b ",
                                  "ovf %0b"},
                                 want.offset, want.length, want.done, want.last, want.ovf,
                                 got.offset, got.length, got.done, got.last, got.ovf);
                end
            end
        end
    end

    initial begin
        #3ms;
        $display("delimiter_tokenizer_core: mismatch");
        $finish;
    end

    initial begin
        predictor_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_split_mode();
        test_stop_mode();
        test_nest_mode();
        test_mode_switch();
        test_set_extremes();
        test_depth_saturation();
        test_random_strings();
        wait_drained();
        if (mismatches == 0) begin
            $display("delimiter_tokenizer_core: match");
        end else begin
            $display("delimiter_tokenizer_core: mismatch");
        end
        $finish;
    end

endmodule
